// ===== rtl/md4_pkg.sv =====
`timescale 1ns / 1ps
// Package for the MD4 digest block: payload structs, block queue links,
// MD4 constants and the small step functions. No dependencies.
package md4_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } md4_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md4_out_t;

    // front -> block queue: word write and block push
    typedef struct packed {
        logic       we;
        logic       push;
        logic       final_blk;
        logic [3:0] idx;
        word_t      data;
    } blk_wr_t;

    // block queue -> front and back
    typedef struct packed {
        logic full;
        logic ready_blk;
        logic final_blk;
    } blk_stat_t;

    // back -> block queue: word read and block release
    typedef struct packed {
        logic       pop;
        logic [3:0] idx;
    } blk_rd_t;

    localparam word_t IV_A     = 32'h6745_2301;
    localparam word_t IV_B     = 32'hefcd_ab89;
    localparam word_t IV_C     = 32'h98ba_dcfe;
    localparam word_t IV_D     = 32'h1032_5476;
    localparam word_t K_ROUND2 = 32'h5a82_7999;
    localparam word_t K_ROUND3 = 32'h6ed9_eba1;
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [5:0] LAST_STEP   = 6'd47;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [3:0] LAST_WORD   = 4'd15;
    localparam logic [3:0] LEN_LO_WORD = 4'd14;

    localparam logic [1:0] STAGE_R1 = 2'd0;
    localparam logic [1:0] STAGE_R2 = 2'd1;
    localparam logic [1:0] STAGE_R3 = 2'd2;

    function automatic word_t rotl32(input word_t v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

    function automatic word_t bswap32(input word_t v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // message word used by a step: straight, column order, bit-reversed order
    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [3:0] j;
        logic [3:0] r;
        j = step[3:0];
        unique case (step[5:4])
            STAGE_R1: r = j;
            STAGE_R2: r = {j[1:0], j[3:2]};
            STAGE_R3: r = {j[0], j[1], j[2], j[3]};
            default:  r = j;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] shift_amt(input logic [5:0] step);
        logic [4:0] s;
        unique case ({step[5:4], step[1:0]})
            {STAGE_R1, 2'd0}: s = 5'd3;
            {STAGE_R1, 2'd1}: s = 5'd7;
            {STAGE_R1, 2'd2}: s = 5'd11;
            {STAGE_R1, 2'd3}: s = 5'd19;
            {STAGE_R2, 2'd0}: s = 5'd3;
            {STAGE_R2, 2'd1}: s = 5'd5;
            {STAGE_R2, 2'd2}: s = 5'd9;
            {STAGE_R2, 2'd3}: s = 5'd13;
            {STAGE_R3, 2'd0}: s = 5'd3;
            {STAGE_R3, 2'd1}: s = 5'd9;
            {STAGE_R3, 2'd2}: s = 5'd11;
            {STAGE_R3, 2'd3}: s = 5'd15;
            default:          s = 5'd3;
        endcase
        return s;
    endfunction

    function automatic word_t round_fn(input logic [1:0] stage, input word_t b,
                                       input word_t c, input word_t d);
        word_t f;
        unique case (stage)
            STAGE_R1: f = (b & c) | (~b & d);
            STAGE_R2: f = (b & c) | (b & d) | (c & d);
            default:  f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic word_t round_const(input logic [1:0] stage);
        word_t k;
        unique case (stage)
            STAGE_R1: k = '0;
            STAGE_R2: k = K_ROUND2;
            default:  k = K_ROUND3;
        endcase
        return k;
    endfunction

    // keep the message bytes below the pad mark
    function automatic word_t pad_keep(input logic [1:0] lane);
        word_t m;
        unique case (lane)
            2'd0: m = 32'h0000_0000;
            2'd1: m = 32'h0000_00ff;
            2'd2: m = 32'h0000_ffff;
            2'd3: m = 32'h00ff_ffff;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/md4_front.sv =====
`timescale 1ns / 1ps
// Front end: packs message bytes into little-endian words, pushes full
// blocks and writes padding and bit length. Depends on md4_pkg.
module md4_front
    import md4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  md4_in_t   in_data,
    input  blk_stat_t q_stat,
    output blk_wr_t   q_wr
);

    localparam logic [0:0] F_IDLE = 1'b0;
    localparam logic [0:0] F_PAD  = 1'b1;

    logic [0:0]  state_reg, state_next;
    logic [60:0] count_reg, count_next;
    word_t       word_reg, word_next;
    logic [3:0]  pad_w_reg, pad_w_next;
    logic        pad_first_reg, pad_first_next;
    logic        pad_len_reg, pad_len_next;

    logic        acc;
    logic [1:0]  lane;
    word_t       word_ins;
    logic [60:0] count_inc;
    logic [60:0] count_end;
    word_t       pad_word;

    assign in_ready  = (state_reg == F_IDLE) && !q_stat.full;
    assign acc       = in_valid && in_ready;
    assign lane      = count_reg[1:0];
    assign count_inc = count_reg + 61'd1;
    assign count_end = in_data.has_byte ? count_inc : count_reg;

    always_comb
    begin
        word_ins = word_reg;
        word_ins[{lane, 3'b000} +: 8] = in_data.data_byte;
    end

    always_comb
    begin
        if (pad_first_reg)
            pad_word = (word_reg & pad_keep(lane)) | (word_t'(PAD_MARK) << {lane, 3'b000});
        else if (pad_len_reg && pad_w_reg == LEN_LO_WORD)
            pad_word = {count_reg[28:0], 3'b000};
        else if (pad_len_reg && pad_w_reg == LAST_WORD)
            pad_word = count_reg[60:29];
        else
            pad_word = '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        word_next      = word_reg;
        pad_w_next     = pad_w_reg;
        pad_first_next = pad_first_reg;
        pad_len_next   = pad_len_reg;
        q_wr           = '0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (acc && in_data.has_byte)
                begin
                    word_next  = word_ins;
                    count_next = count_inc;
                    if (lane == 2'd3)
                    begin
                        q_wr.we   = 1'b1;
                        q_wr.idx  = count_reg[5:2];
                        q_wr.data = word_ins;
                        q_wr.push = (count_reg[5:2] == LAST_WORD);
                    end
                end
                if (acc && in_data.last)
                begin
                    state_next     = F_PAD;
                    pad_w_next     = count_end[5:2];
                    pad_first_next = 1'b1;
                    pad_len_next   = (count_end[5:0] < LEN_POS);
                end
            end
            F_PAD:
            begin
                if (!q_stat.full)
                begin
                    q_wr.we        = 1'b1;
                    q_wr.idx       = pad_w_reg;
                    q_wr.data      = pad_word;
                    pad_first_next = 1'b0;
                    pad_w_next     = pad_w_reg + 4'd1;
                    if (pad_w_reg == LAST_WORD)
                    begin
                        q_wr.push      = 1'b1;
                        q_wr.final_blk = pad_len_reg;
                        pad_len_next   = 1'b1;
                        if (pad_len_reg)
                        begin
                            state_next = F_IDLE;
                            count_next = '0;
                        end
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            count_reg     <= '0;
            pad_first_reg <= 1'b0;
            pad_len_reg   <= 1'b0;
            pad_w_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pad_first_reg <= pad_first_next;
            pad_len_reg   <= pad_len_next;
            pad_w_reg     <= pad_w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// ===== rtl/md4_blkq.sv =====
`timescale 1ns / 1ps
// Two-slot block queue between front and back: sixteen words per slot
// plus a final-block flag. Depends on md4_pkg.
module md4_blkq
    import md4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  blk_wr_t   q_wr,
    input  blk_rd_t   q_rd,
    output blk_stat_t q_stat,
    output word_t     rd_word
);

    word_t      words_reg [2][16];
    logic [1:0] valid_reg, valid_next;
    logic [1:0] final_reg, final_next;
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;

    assign q_stat.full      = &valid_reg;
    assign q_stat.ready_blk = valid_reg[head_reg];
    assign q_stat.final_blk = final_reg[head_reg];
    assign rd_word          = words_reg[head_reg][q_rd.idx];

    always_comb
    begin
        valid_next = valid_reg;
        final_next = final_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (q_wr.push)
        begin
            valid_next[tail_reg] = 1'b1;
            final_next[tail_reg] = q_wr.final_blk;
            tail_next            = ~tail_reg;
        end
        if (q_rd.pop)
        begin
            valid_next[head_reg] = 1'b0;
            head_next            = ~head_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            final_reg <= '0;
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            final_reg <= final_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.we)
            words_reg[tail_reg][q_wr.idx] <= q_wr.data;
    end

endmodule

// ===== rtl/md4_back.sv =====
`timescale 1ns / 1ps
// Back end: 48-step MD4 compression, one step per cycle, chaining value
// and digest word output. Depends on md4_pkg.
module md4_back
    import md4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  blk_stat_t q_stat,
    input  word_t     rd_word,
    output blk_rd_t   q_rd,
    output logic      out_valid,
    input  logic      out_ready,
    output md4_out_t  out_data
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RUN  = 2'd1;
    localparam logic [1:0] B_ADD  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic [1:0] k_reg, k_next;
    word_t      cv_reg [4];
    word_t      cv_next [4];
    word_t      a_reg, b_reg, c_reg, d_reg;
    word_t      a_next, b_next, c_next, d_next;
    word_t      sum;

    assign sum      = a_reg + round_fn(step_reg[5:4], b_reg, c_reg, d_reg)
                    + rd_word + round_const(step_reg[5:4]);

    assign out_valid            = (state_reg == B_OUT);
    assign out_data.digest_word = bswap32(cv_reg[k_reg]);
    assign out_data.word_index  = k_reg;
    assign out_data.last_word   = (k_reg == 2'd3);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        cv_next    = cv_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        q_rd.idx   = msg_index(step_reg);
        q_rd.pop   = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_stat.ready_blk)
                begin
                    a_next     = cv_reg[0];
                    b_next     = cv_reg[1];
                    c_next     = cv_reg[2];
                    d_next     = cv_reg[3];
                    step_next  = '0;
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                a_next    = d_reg;
                d_next    = c_reg;
                c_next    = b_reg;
                b_next    = rotl32(sum, shift_amt(step_reg));
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                    state_next = B_ADD;
            end
            B_ADD:
            begin
                cv_next[0] = cv_reg[0] + a_reg;
                cv_next[1] = cv_reg[1] + b_reg;
                cv_next[2] = cv_reg[2] + c_reg;
                cv_next[3] = cv_reg[3] + d_reg;
                q_rd.pop   = 1'b1;
                k_next     = '0;
                state_next = q_stat.final_blk ? B_OUT : B_IDLE;
            end
            B_OUT:
            begin
                if (out_ready)
                begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        cv_next[0] = IV_A;
                        cv_next[1] = IV_B;
                        cv_next[2] = IV_C;
                        cv_next[3] = IV_D;
                        state_next = B_IDLE;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
            k_reg     <= '0;
            cv_reg[0] <= IV_A;
            cv_reg[1] <= IV_B;
            cv_reg[2] <= IV_C;
            cv_reg[3] <= IV_D;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            cv_reg    <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

endmodule

// ===== rtl/md4_message_digest_top.sv =====
`timescale 1ns / 1ps
// Top level of the MD4 digest block: front end, two-slot block queue and
// compression back end. Depends on md4_pkg, md4_front, md4_blkq, md4_back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_ready  | md4_in_t  (data_byte,has_byte,last)
//  out     | output    | out_valid/out_ready  | md4_out_t (digest_word,word_index,
//          |           |                      |            last_word)
//
// Flow: the front takes one byte transaction per cycle while a block slot
// is free. The back handles a block in order (load, 48 MD4 steps on one
// shared step unit, chaining add) and finishes before the next block is
// full, so the sustained rate is one byte per cycle outside padding and
// output stalls. A last transaction holds the input while the padding
// words go into the queue (one word per cycle, from the open word up to
// word 15, plus 16 more when the length spills into a second block), longer
// while both slots are taken; the digest follows as four output transactions
// after the final block is compressed.
// Reset: asynchronous, active low; the chaining value returns to the MD4
// initial values and both queue slots are empty. No clearing pass.
// Stalls: a stall on out holds the back end; the front keeps filling the
// queue until both slots are taken, then drops in_ready.
module md4_message_digest_top
    import md4_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  md4_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output md4_out_t out_data
);

    blk_wr_t   q_wr;
    blk_rd_t   q_rd;
    blk_stat_t q_stat;
    word_t     rd_word;

    // accept bytes, pack words, write padding and length
    md4_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .q_wr     (q_wr)
    );

    // hold up to two finished blocks between the two sides
    md4_blkq u_blkq (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_wr    (q_wr),
        .q_rd    (q_rd),
        .q_stat  (q_stat),
        .rd_word (rd_word)
    );

    // compress blocks, advance the chaining value, emit the digest
    md4_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .rd_word   (rd_word),
        .q_rd      (q_rd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/md4_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the MD4 digest block, bound to the top level.
// Depends on md4_pkg.
module md4_chk
    import md4_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input md4_out_t out_data
);

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("digest word changed while stalled");

    // last_word marks exactly the D word
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_word == (out_data.word_index == 2'd3)))
        else $error("last_word does not match word_index");

    // digest words follow back to back in order A, B, C, D
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_word |=>
            out_valid && out_data.word_index == $past(out_data.word_index) + 2'd1)
        else $error("digest words out of order");

    // the digest ends after its fourth word
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_word |=> !out_valid)
        else $error("extra digest word after the last");

endmodule

bind md4_message_digest_top md4_chk u_chk (.*);

// ===== tb/sv/md4_message_digest_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for md4_message_digest_top: byte streams go in, digest words
// come out and are checked against an MD4 predictor kept inside the bench.
// Depends on md4_pkg (payload structs) and md4_message_digest_top.
module md4_message_digest_top_tb;
    import md4_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    // Slowest legal gap between transactions: the padding words, two
    // compressions and the output stalls on each digest word.
    // The limit allows for that several times over.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int CALM_TAIL      = 40;
    localparam int RANDOM_ITEMS   = 145;
    localparam int MIN_MESSAGES   = 3;

    // MD4 starting chaining value, round constants and pad byte
    localparam logic [31:0] START_A  = 32'h6745_2301;
    localparam logic [31:0] START_B  = 32'hefcd_ab89;
    localparam logic [31:0] START_C  = 32'h98ba_dcfe;
    localparam logic [31:0] START_D  = 32'h1032_5476;
    localparam logic [31:0] ADD_R2   = 32'h5a82_7999;
    localparam logic [31:0] ADD_R3   = 32'h6ed9_eba1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    md4_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    md4_out_t out_data;

    md4_message_digest_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Byte transactions still to be driven, and digest words still owed by the block.
    md4_in_t  pending_items [$];
    md4_out_t digests_due [$];

    // Predictor state: chaining value, the 64-byte block being filled, byte count.
    logic [31:0] chain_val [4];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_bytes;

    int          errors        = 0;
    int          words_checked = 0;
    int          digests_done  = 0;
    int          bytes_sent    = 0;
    int          messages_sent = 0;
    int          in_gap        = 0;
    int          out_hold      = 0;
    int          stall_cycles  = 0;
    logic [31:0] cycle_cnt     = '0;

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // MD4 predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void md4_restart();
        chain_val[0] = START_A;
        chain_val[1] = START_B;
        chain_val[2] = START_C;
        chain_val[3] = START_D;
        msg_bytes    = '0;
    endfunction

    // Compress msg_block into the chaining value: 48 steps in three rounds of 16,
    // then add the working registers back in (chaining after every block).
    function automatic void md4_compress();
        logic [31:0] r [4];
        logic [31:0] f;
        logic [31:0] k;
        logic [31:0] x;
        logic [31:0] t;
        logic [3:0]  j;
        logic [3:0]  w;
        int unsigned s;
        int          wi;
        for (int i = 0; i < 4; i++)
            r[i] = chain_val[i];
        for (int i = 0; i < 48; i++)
        begin
            j = 4'(i % 16);
            if (i < 16)
            begin
                f = (r[1] & r[2]) | (~r[1] & r[3]);
                k = '0;
                w = j;
                case (j[1:0])
                    2'd0:    s = 3;
                    2'd1:    s = 7;
                    2'd2:    s = 11;
                    default: s = 19;
                endcase
            end
            else if (i < 32)
            begin
                // column order: message words 0,4,8,12,1,5,...
                f = (r[1] & r[2]) | (r[1] & r[3]) | (r[2] & r[3]);
                k = ADD_R2;
                w = {j[1:0], j[3:2]};
                case (j[1:0])
                    2'd0:    s = 3;
                    2'd1:    s = 5;
                    2'd2:    s = 9;
                    default: s = 13;
                endcase
            end
            else
            begin
                // bit-reversed order: message words 0,8,4,12,2,...
                f = r[1] ^ r[2] ^ r[3];
                k = ADD_R3;
                w = {j[0], j[1], j[2], j[3]};
                case (j[1:0])
                    2'd0:    s = 3;
                    2'd1:    s = 9;
                    2'd2:    s = 11;
                    default: s = 15;
                endcase
            end
            wi = 4 * int'(w);
            x  = {msg_block[wi + 3], msg_block[wi + 2], msg_block[wi + 1], msg_block[wi]};
            t  = rol32(r[0] + f + x + k, s);
            r[0] = r[3];
            r[3] = r[2];
            r[2] = r[1];
            r[1] = t;
        end
        for (int i = 0; i < 4; i++)
            chain_val[i] = chain_val[i] + r[i];
    endfunction

    // Take one accepted input transaction; on a last one, pad, finish and queue
    // the four byte-swapped digest words, then start a fresh message.
    function automatic void md4_take_item(input md4_in_t it);
        int          pos;
        logic [63:0] bit_len;
        md4_out_t    word;
        if (it.has_byte)
        begin
            msg_block[msg_bytes[5:0]] = it.data_byte;
            msg_bytes = msg_bytes + 61'd1;
            if (msg_bytes[5:0] == 6'd0)
                md4_compress();
        end
        if (it.last)
        begin
            pos = int'(msg_bytes[5:0]);
            msg_block[pos] = PAD_BYTE;
            pos++;
            // no room left for the length: spill into a second block
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    msg_block[pos] = '0;
                    pos++;
                end
                md4_compress();
                pos = 0;
            end
            while (pos < 56)
            begin
                msg_block[pos] = '0;
                pos++;
            end
            bit_len = {msg_bytes, 3'b000};
            for (int i = 0; i < 8; i++)
                msg_block[56 + i] = bit_len[8 * i +: 8];
            md4_compress();
            for (int i = 0; i < 4; i++)
            begin
                word.digest_word = {chain_val[i][7:0], chain_val[i][15:8],
                                    chain_val[i][23:16], chain_val[i][31:24]};
                word.word_index  = 2'(i);
                word.last_word   = (i == 3);
                digests_due.push_back(word);
            end
            md4_restart();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        errors++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_digest_word(input md4_out_t got);
        md4_out_t want;
        if (digests_due.size() == 0)
        begin
            flag_error($sformatf("digest word %08h index %0d with none outstanding",
                                 got.digest_word, got.word_index));
        end
        else
        begin
            want = digests_due.pop_front();
            words_checked++;
            if (got.digest_word !== want.digest_word)
                flag_error($sformatf("digest word %0d: got %08h, want %08h",
                                     want.word_index, got.digest_word, want.digest_word));
            if (got.word_index !== want.word_index)
                flag_error($sformatf("word index: got %0d, want %0d",
                                     got.word_index, want.word_index));
            if (got.last_word !== want.last_word)
                flag_error($sformatf("last word flag on index %0d: got %0b, want %0b",
                                     want.word_index, got.last_word, want.last_word));
            if (want.last_word)
                digests_done++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void queue_item(input logic [7:0] d, input logic has, input logic fin);
        md4_in_t it;
        it.data_byte = d;
        it.has_byte  = has;
        it.last      = fin;
        pending_items.push_back(it);
        if (has)
            bytes_sent++;
        if (fin)
            messages_sent++;
    endfunction

    // Idle only in alternate windows of the cycle counter (bit 8 low), and never in the tail of the run.
    function automatic bit idling_allowed();
        return (cycle_cnt[8] == 1'b0) && (pending_items.size() >= CALM_TAIL);
    endfunction

    initial
    begin : stimulus
        int len;
        int msgs;
        int random_items;
        bit end_marker;
        md4_restart();
        for (int i = 0; i < 64; i++)
            msg_block[i] = '0;

        // Directed part.
        queue_item(8'hff, 1'b0, 1'b0);      // idle transaction: block must ignore it
        queue_item(8'ha5, 1'b0, 1'b1);      // empty end marker: digest of the empty string
        queue_item(8'h61, 1'b1, 1'b0);      // "abc", last flag riding on the final byte
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        queue_item(8'hff, 1'b1, 1'b1);      // single all-ones byte with last
        queue_item(8'h00, 1'b1, 1'b1);      // single zero byte with last
        queue_item(8'h00, 1'b1, 1'b0);      // two bytes with an idle between, closed by
        queue_item(8'h3c, 1'b0, 1'b0);      // a separate end marker
        queue_item(8'hff, 1'b1, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b1);
        queue_item(8'h00, 1'b0, 1'b1);      // empty message right after an end marker
        queue_item(8'h00, 1'b0, 1'b0);

        // Random part: whole messages with random content and random noise.
        // The first two hit the two-block padding case and an exact block.
        msgs         = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || msgs < MIN_MESSAGES)
        begin
            if (msgs == 0)
                len = 56;
            else if (msgs == 1)
                len = 64;
            else if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       len = 55;
                    1:       len = 57;
                    2:       len = 63;
                    3:       len = 65;
                    4:       len = 120;
                    default: len = 128;
                endcase
            end
            else
                len = $urandom_range(0, 24);
            end_marker = (len == 0) || ($urandom_range(0, 3) == 0);
            for (int b = 0; b < len; b++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    queue_item(8'($urandom), 1'b0, 1'b0);
                    random_items++;
                end
                queue_item(8'($urandom), 1'b1, !end_marker && (b == len - 1));
                random_items++;
            end
            if (end_marker)
            begin
                queue_item(8'($urandom), 1'b0, 1'b1);
                random_items++;
            end
            msgs++;
        end
    end

    // ------------------------------------------------------------------
    // Input driver: advance to the next pending transaction once the current one
    // is accepted (or none is offered); hold valid and payload until then.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (pending_items.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_items.pop_front();
                // open an idle burst after this transaction now and then
                if (idling_allowed() && $urandom_range(0, 5) == 0)
                    in_gap <= $urandom_range(1, 9);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side: stall in random bursts while idling is allowed, otherwise stay ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold  <= 0;
        end
        else if (out_hold != 0)
        begin
            out_ready <= 1'b0;
            out_hold  <= out_hold - 1;
        end
        else if (idling_allowed() && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            out_hold  <= $urandom_range(0, 8);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitors: sample at the edge where the handshake completes.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            md4_take_item(in_data);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_digest_word(out_data);
    end

    // Watchdog: count cycles in which neither channel completes a transaction.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 32'd1;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: %0d cycles without a transaction, %0d words outstanding",
                     stall_cycles, digests_due.size());
            $display("FAIL md4_message_digest_top");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Reset, then wait for the stimulus to drain and every digest to arrive.
    // ------------------------------------------------------------------
    initial
    begin : run_control
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_items.size() != 0 || in_valid || digests_due.size() != 0)
            @(posedge clk);
        // give any stray extra output a chance to show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d messages (%0d bytes): empty, single-byte, abc and",
                 messages_sent, bytes_sent);
        $display("padding-boundary lengths; %0d digests, %0d words checked, %0d errors",
                 digests_done, words_checked, errors);
        if (errors == 0)
            $display("PASS md4_message_digest_top");
        else
            $display("FAIL md4_message_digest_top");
        $finish;
    end

endmodule
